@@ design/gnf_pkg.sv @@
`default_nettype none
package gnf_pkg;

  localparam int POS_W      = 32;
  localparam int SEED_W     = 32;
  localparam int CNT_W      = 4;
  localparam int LAC_W      = 16;
  localparam int LAC_FRAC   = 12;
  localparam int GAIN_W     = 16;
  localparam int GAIN_FRAC  = 15;
  localparam int NOISE_W    = 19;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int MAX_OCT_DEF  = 8;
  localparam int POS_FRAC_DEF = 16;
  localparam int MAX_OCT_LIM  = 16;
  localparam int OCT_W        = $clog2(MAX_OCT_LIM + 1);

  localparam int FRAC_W = 16;
  localparam int FADE_W = 21;
  localparam int VAL_W  = 20;
  localparam int AMP_W  = 16 + MAX_OCT_LIM;
  localparam int TOT_W  = AMP_W;
  localparam int PROD_W = VAL_W + AMP_W + 1;
  localparam int SUM_W  = PROD_W + 4;
  localparam int Q_W    = NOISE_W;

  localparam int ONE_Q16   = 65536;
  localparam int AMP_ONE   = 32768;
  localparam int NOISE_MAX = (1 << (NOISE_W - 1)) - 1;

  localparam logic [31:0] PRIME_X    = 32'd1619;
  localparam logic [31:0] PRIME_Y    = 32'd31337;
  localparam logic [31:0] PRIME_Z    = 32'd6971;
  localparam logic [31:0] HASH_MUL   = 32'd60493;
  localparam logic [31:0] HASH_ADD   = 32'd19990303;
  localparam int          HASH_SHIFT = 13;

  localparam logic [SEED_W-1:0] SEED_RST    = '0;
  localparam logic              FRACTAL_RST = 1'b0;
  localparam logic [CNT_W-1:0]  COUNT_RST   = 4'd3;
  localparam logic [LAC_W-1:0]  LAC_RST     = 16'd8192;
  localparam logic [GAIN_W-1:0] GAIN_RST    = 16'd16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEED    = 3'd0,
    CFG_FRACTAL = 3'd1,
    CFG_COUNT   = 3'd2,
    CFG_LAC     = 3'd3,
    CFG_GAIN    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [POS_W-1:0]  px;
    logic [POS_W-1:0]  py;
    logic [POS_W-1:0]  pz;
    logic [SEED_W-1:0] seed;
    logic [SUM_W-1:0]  sum;
    logic [AMP_W-1:0]  amp;
    logic [TOT_W-1:0]  total;
    logic [OCT_W-1:0]  oct_n;
    logic              last;
  } gnf_oct_t;

  typedef struct packed {
    logic [SUM_W-1:0] rem;
    logic [TOT_W-1:0] total;
    logic [Q_W-1:0]   quo;
    logic             neg;
    logic             sat;
    logic             last;
  } gnf_div_t;

endpackage
`default_nettype wire

@@ design/gnf_stream_ifs.sv @@
`default_nettype none
interface gnf_in_if;
  logic                      valid;
  logic                      ready;
  logic [gnf_pkg::POS_W-1:0] x_pos;
  logic [gnf_pkg::POS_W-1:0] y_pos;
  logic [gnf_pkg::POS_W-1:0] z_pos;
  logic                      last_point;

  modport source (output valid, x_pos, y_pos, z_pos, last_point, input ready);
  modport sink   (input valid, x_pos, y_pos, z_pos, last_point, output ready);
endinterface

interface gnf_out_if;
  logic                        valid;
  logic                        ready;
  logic [gnf_pkg::NOISE_W-1:0] noise_value;
  logic                        last_point_out;

  modport source (output valid, noise_value, last_point_out, input ready);
  modport sink   (input valid, noise_value, last_point_out, output ready);
endinterface
`default_nettype wire

@@ design/gnf_octave_cell.sv @@
`default_nettype none
module gnf_octave_cell #(
  parameter int OCT_IDX       = 0,
  parameter int POS_FRAC_BITS = gnf_pkg::POS_FRAC_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_v,
  input  gnf_pkg::gnf_oct_t          in_d,
  input  logic [gnf_pkg::LAC_W-1:0]  lacunarity,
  input  logic [gnf_pkg::GAIN_W-1:0] octave_gain,
  output logic                       out_v,
  output gnf_pkg::gnf_oct_t          out_d
);
  import gnf_pkg::*;

  localparam int LAT = 11;

  typedef logic signed [VAL_W-1:0]  val_t;
  typedef logic signed [FADE_W-1:0] fade_t;
  typedef logic [FRAC_W-1:0]        frac_t;

  localparam logic [31:0] PRIME [3] = '{PRIME_X, PRIME_Y, PRIME_Z};

  function automatic frac_t frac_of(input logic [POS_W-1:0] p);
    logic [POS_W+FRAC_W-1:0] t;
    t = {p, {FRAC_W{1'b0}}} >> POS_FRAC_BITS;
    return t[FRAC_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] cell_of(input logic [POS_W-1:0] p);
    return POS_W'($signed(p) >>> POS_FRAC_BITS);
  endfunction

  function automatic fade_t fade_mul(input fade_t r, input frac_t t);
    logic signed [FADE_W+FRAC_W:0] p;
    p = r * $signed({1'b0, t});
    return FADE_W'(p >>> FRAC_W);
  endfunction

  function automatic val_t grad(input logic [3:0] k, input val_t x, input val_t y,
                                input val_t z);
    val_t u;
    val_t v;
    u = (k < 4'd8) ? x : y;
    if (k < 4'd4) begin
      v = y;
    end else if (k == 4'd12 || k == 4'd14) begin
      v = x;
    end else begin
      v = z;
    end
    return (k[0] ? -u : u) + (k[1] ? -v : v);
  endfunction

  function automatic val_t lerp(input val_t a, input val_t b, input fade_t w);
    logic signed [VAL_W:0]        d;
    logic signed [VAL_W+FADE_W:0] p;
    d = (VAL_W+1)'(b) - (VAL_W+1)'(a);
    p = d * w;
    return a + VAL_W'(p >>> FRAC_W);
  endfunction

  logic [LAT-1:0]    v_r;
  logic [POS_W-1:0]  pos [3];
  logic [POS_W-1:0]  cc [3];
  frac_t             ff [3];
  logic signed [POS_W+LAC_W:0]   sp [3];
  logic [AMP_W+GAIN_W-1:0]       ap;
  logic              act;
  gnf_oct_t          c_nxt;
  gnf_oct_t          o_nxt;
  val_t              off [3][2];

  logic [31:0]       hc_r [3][2];
  logic [SEED_W-1:0] seed1_r;
  frac_t             f_r [1:5][3];
  fade_t             fr_r [1:5][3];
  fade_t             wd_r [6:8][3];
  logic [31:0]       h2_r [8];
  logic [31:0]       hh3_r [8];
  logic [31:0]       hd3_r [8];
  logic [31:0]       hm4_r [8];
  logic [31:0]       hd4_r [8];
  logic [31:0]       hp5_r [8];
  val_t              g6_r [8];
  val_t              l7_r [4];
  val_t              m8_r [2];
  val_t              n9_r;
  logic signed [PROD_W-1:0] p10_r;
  gnf_oct_t          c_r [1:10];
  logic [AMP_W-1:0]  amp_r [1:9];
  logic              act_r [1:9];
  gnf_oct_t          out_d_r;

  always_comb begin
    pos[0] = in_d.px;
    pos[1] = in_d.py;
    pos[2] = in_d.pz;
    for (int a = 0; a < 3; a++) begin
      cc[a] = cell_of(pos[a]);
      ff[a] = frac_of(pos[a]);
      sp[a] = $signed(pos[a]) * $signed({1'b0, lacunarity});
    end
    ap  = in_d.amp * octave_gain;
    act = OCT_W'(OCT_IDX) < in_d.oct_n;
    c_nxt       = in_d;
    c_nxt.px    = sp[0][LAC_FRAC+POS_W-1:LAC_FRAC];
    c_nxt.py    = sp[1][LAC_FRAC+POS_W-1:LAC_FRAC];
    c_nxt.pz    = sp[2][LAC_FRAC+POS_W-1:LAC_FRAC];
    c_nxt.seed  = in_d.seed + SEED_W'(1);
    c_nxt.amp   = ap[GAIN_FRAC+AMP_W-1:GAIN_FRAC];
    c_nxt.total = in_d.total + (act ? in_d.amp : '0);
    for (int a = 0; a < 3; a++) begin
      off[a][0] = val_t'(f_r[5][a]);
      off[a][1] = val_t'(f_r[5][a]) - val_t'(ONE_Q16);
    end
    o_nxt     = c_r[10];
    o_nxt.sum = c_r[10].sum + SUM_W'(p10_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAT-2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        hc_r[a][0] <= cc[a] * PRIME[a];
        hc_r[a][1] <= (cc[a] + 32'd1) * PRIME[a];
        f_r[1][a]  <= ff[a];
        fr_r[1][a] <= fade_t'(6) * $signed({{(FADE_W-FRAC_W){1'b0}}, ff[a]})
                      - fade_t'(15 * ONE_Q16);
        fr_r[2][a] <= fade_mul(fr_r[1][a], f_r[1][a]) + fade_t'(10 * ONE_Q16);
        for (int s = 3; s <= 5; s++) begin
          fr_r[s][a] <= fade_mul(fr_r[s-1][a], f_r[s-1][a]);
        end
        for (int s = 2; s <= 5; s++) begin
          f_r[s][a] <= f_r[s-1][a];
        end
        wd_r[6][a] <= fr_r[5][a];
        wd_r[7][a] <= wd_r[6][a];
        wd_r[8][a] <= wd_r[7][a];
      end
      seed1_r <= in_d.seed;

      for (int i = 0; i < 8; i++) begin
        h2_r[i]  <= (hc_r[0][i[0]] + hc_r[1][i[1]] + hc_r[2][i[2]]) ^ seed1_r;
        hh3_r[i] <= h2_r[i] * h2_r[i];
        hd3_r[i] <= h2_r[i];
        hm4_r[i] <= hh3_r[i] * HASH_MUL + HASH_ADD;
        hd4_r[i] <= hd3_r[i];
        hp5_r[i] <= hm4_r[i] * hd4_r[i];
        g6_r[i]  <= grad(hp5_r[i][3:0] ^ hp5_r[i][HASH_SHIFT+3:HASH_SHIFT],
                         off[0][i[0]], off[1][i[1]], off[2][i[2]]);
      end
      for (int j = 0; j < 4; j++) begin
        l7_r[j] <= lerp(g6_r[2*j], g6_r[2*j+1], wd_r[6][0]);
      end
      m8_r[0] <= lerp(l7_r[0], l7_r[1], wd_r[7][1]);
      m8_r[1] <= lerp(l7_r[2], l7_r[3], wd_r[7][1]);
      n9_r    <= lerp(m8_r[0], m8_r[1], wd_r[8][2]);
      if (act_r[9]) begin
        p10_r <= n9_r * $signed({1'b0, amp_r[9]});
      end else begin
        p10_r <= '0;
      end

      c_r[1]   <= c_nxt;
      amp_r[1] <= in_d.amp;
      act_r[1] <= act;
      for (int s = 2; s <= 10; s++) begin
        c_r[s] <= c_r[s-1];
      end
      for (int s = 2; s <= 9; s++) begin
        amp_r[s] <= amp_r[s-1];
        act_r[s] <= act_r[s-1];
      end
      out_d_r <= o_nxt;
    end
  end

  assign out_v = v_r[LAT-1];
  assign out_d = out_d_r;

endmodule
`default_nettype wire

@@ design/gnf_div_cell.sv @@
`default_nettype none
module gnf_div_cell #(
  parameter int BIT = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_v,
  input  gnf_pkg::gnf_div_t in_d,
  output logic              out_v,
  output gnf_pkg::gnf_div_t out_d
);
  import gnf_pkg::*;

  logic [SUM_W-1:0] dvs;
  logic             take;
  gnf_div_t         d_nxt;
  gnf_div_t         d_r;
  logic             v_r;

  always_comb begin
    dvs   = SUM_W'(in_d.total) << BIT;
    take  = in_d.rem >= dvs;
    d_nxt = in_d;
    if (take) begin
      d_nxt.rem      = in_d.rem - dvs;
      d_nxt.quo[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign out_v = v_r;
  assign out_d = d_r;

endmodule
`default_nettype wire

@@ design/gradient_noise_3d_fractal.sv @@
// Throughput: one request per cycle while the skid is empty; each octave cell is
// an 11-stage pipeline and the normalising divide is a chain of one-bit cells, so
// nothing iterates.
// A two-entry output register/skid keeps input ready high while one result waits.
// Reset (synchronous, active low): configuration returns to defaults, all valids clear.
`default_nettype none
module gradient_noise_3d_fractal #(
  parameter int MAX_OCTAVES   = gnf_pkg::MAX_OCT_DEF,
  parameter int POS_FRAC_BITS = gnf_pkg::POS_FRAC_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  gnf_in_if.sink                          in_ch,
  gnf_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [gnf_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [gnf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import gnf_pkg::*;

  logic [SEED_W-1:0] seed_r;
  logic              fractal_r;
  logic [CNT_W-1:0]  count_r;
  logic [LAC_W-1:0]  lac_r;
  logic [GAIN_W-1:0] gain_r;

  logic              en;
  logic [OCT_W-1:0]  n_nxt;
  gnf_oct_t          entry;
  logic              oct_v [MAX_OCTAVES+1];
  gnf_oct_t          oct_d [MAX_OCTAVES+1];

  logic              p1_v_r;
  logic [SUM_W-1:0]  p1_abs_r;
  logic              p1_neg_r;
  logic [TOT_W-1:0]  p1_total_r;
  logic              p1_last_r;
  logic              d0_v_r;
  gnf_div_t          d0_r;
  logic              div_v [Q_W+1];
  gnf_div_t          div_d [Q_W+1];

  gnf_div_t          fin;
  logic [NOISE_W-1:0] fin_val;
  logic              out_v_r;
  logic [NOISE_W-1:0] out_val_r;
  logic              out_last_r;
  logic              sk_v_r;
  logic [NOISE_W-1:0] sk_val_r;
  logic              sk_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r    <= SEED_RST;
      fractal_r <= FRACTAL_RST;
      count_r   <= COUNT_RST;
      lac_r     <= LAC_RST;
      gain_r    <= GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_SEED:    seed_r    <= cfg_data[SEED_W-1:0];
        CFG_FRACTAL: fractal_r <= cfg_data[0];
        CFG_COUNT:   count_r   <= cfg_data[CNT_W-1:0];
        CFG_LAC:     lac_r     <= cfg_data[LAC_W-1:0];
        CFG_GAIN:    gain_r    <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign en          = !sk_v_r;
  assign in_ch.ready = en;

  always_comb begin
    priority if (!fractal_r || count_r == '0) begin
      n_nxt = OCT_W'(1);
    end else if (OCT_W'(count_r) > OCT_W'(MAX_OCTAVES)) begin
      n_nxt = OCT_W'(MAX_OCTAVES);
    end else begin
      n_nxt = OCT_W'(count_r);
    end
    entry.px    = in_ch.x_pos;
    entry.py    = in_ch.y_pos;
    entry.pz    = in_ch.z_pos;
    entry.seed  = seed_r;
    entry.sum   = '0;
    entry.amp   = AMP_W'(AMP_ONE);
    entry.total = '0;
    entry.oct_n = n_nxt;
    entry.last  = in_ch.last_point;
  end

  assign oct_v[0] = in_ch.valid;
  assign oct_d[0] = entry;

  for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_oct
    gnf_octave_cell #(
      .OCT_IDX       (k),
      .POS_FRAC_BITS (POS_FRAC_BITS)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .en          (en),
      .in_v        (oct_v[k]),
      .in_d        (oct_d[k]),
      .lacunarity  (lac_r),
      .octave_gain (gain_r),
      .out_v       (oct_v[k+1]),
      .out_d       (oct_d[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      d0_v_r <= 1'b0;
    end else if (en) begin
      p1_v_r <= oct_v[MAX_OCTAVES];
      d0_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_neg_r   <= oct_d[MAX_OCTAVES].sum[SUM_W-1];
      p1_abs_r   <= oct_d[MAX_OCTAVES].sum[SUM_W-1] ? -oct_d[MAX_OCTAVES].sum
                                                    : oct_d[MAX_OCTAVES].sum;
      p1_total_r <= oct_d[MAX_OCTAVES].total;
      p1_last_r  <= oct_d[MAX_OCTAVES].last;
      d0_r.rem   <= p1_abs_r;
      d0_r.total <= p1_total_r;
      d0_r.quo   <= '0;
      d0_r.neg   <= p1_neg_r;
      d0_r.sat   <= p1_abs_r >= (SUM_W'(p1_total_r) << Q_W);
      d0_r.last  <= p1_last_r;
    end
  end

  assign div_v[0] = d0_v_r;
  assign div_d[0] = d0_r;

  for (genvar j = 0; j < Q_W; j++) begin : g_div
    gnf_div_cell #(
      .BIT (Q_W - 1 - j)
    ) u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .in_v  (div_v[j]),
      .in_d  (div_d[j]),
      .out_v (div_v[j+1]),
      .out_d (div_d[j+1])
    );
  end

  always_comb begin
    fin = div_d[Q_W];
    if (fin.neg) begin
      fin_val = (fin.sat || fin.quo > Q_W'(NOISE_MAX + 1)) ? NOISE_W'(-(NOISE_MAX + 1))
                                                           : NOISE_W'(0) - fin.quo;
    end else begin
      fin_val = (fin.sat || fin.quo > Q_W'(NOISE_MAX)) ? NOISE_W'(NOISE_MAX) : fin.quo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else if (!out_v_r || out_ch.ready) begin
      if (sk_v_r) begin
        out_v_r    <= 1'b1;
        out_val_r  <= sk_val_r;
        out_last_r <= sk_last_r;
        sk_v_r     <= 1'b0;
      end else begin
        out_v_r    <= div_v[Q_W];
        out_val_r  <= fin_val;
        out_last_r <= fin.last;
      end
    end else if (div_v[Q_W] && en) begin
      sk_v_r    <= 1'b1;
      sk_val_r  <= fin_val;
      sk_last_r <= fin.last;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.noise_value    = out_val_r;
  assign out_ch.last_point_out = out_last_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    sk_v_r |-> out_v_r)
    else $error("skid holds a result while the output register is empty");

  a_octave_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid |-> (entry.oct_n >= OCT_W'(1) && entry.oct_n <= OCT_W'(MAX_OCTAVES)))
    else $error("octave count out of range at entry");

  a_total_floor: assert property (@(posedge clk) disable iff (!rst_n)
    div_v[0] |-> div_d[0].total >= TOT_W'(AMP_ONE))
    else $error("amplitude total below one at divider");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(sk_v_r) |-> $past(out_v_r && !out_ch.ready))
    else $error("skid filled while output was free");

endmodule
`default_nettype wire
